### rtl/lca_pkg.sv
// ----------------------------------------------------------------------------
// lca_pkg
// Shared types, constants and address helper for the ancestor / LCA engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lca_pkg;

    localparam int NODES       = 1024;
    localparam int LEVELS      = 12;
    localparam int NODE_W      = 10;
    localparam int DEPTH_W     = 10;
    localparam int K_W         = 12;
    localparam int LVL_W       = $clog2(LEVELS + 1);
    localparam int ANC_DEPTH   = NODES * LEVELS;
    localparam int ANC_AW      = $clog2(ANC_DEPTH);
    localparam int QUEUE_DEPTH = 2;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 24;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    typedef logic [NODE_W-1:0]  node_t;
    typedef logic [DEPTH_W-1:0] depth_t;
    typedef logic [LVL_W-1:0]   lvl_t;
    typedef logic [ANC_AW-1:0]  anc_addr_t;

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_KTH  = 2'd1,
        CMD_LCA  = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    // One request as the front end hands it to the engine
    typedef struct packed {
        cmd_t            cmd;
        node_t           node_a;
        node_t           node_b;
        logic            is_root;
        logic [K_W-1:0]  count_k;
    } req_t;

    typedef struct packed {
        logic  valid;
        node_t node;
    } anc_entry_t;

    function automatic anc_addr_t anc_addr(input node_t node, input lvl_t lvl);
        anc_addr_t base;
        base = ANC_AW'(node) * ANC_AW'(LEVELS);
        return base + ANC_AW'(lvl);
    endfunction

endpackage

`default_nettype wire

### rtl/lca_queue.sv
// ----------------------------------------------------------------------------
// lca_queue
// Short request queue between the front end and the lifting engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lca_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire lca_pkg::req_t push_req,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output lca_pkg::req_t      pop_req
);

    localparam int PTR_W = $clog2(lca_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(lca_pkg::QUEUE_DEPTH + 1);

    lca_pkg::req_t     slot_reg [lca_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != CNT_W'(lca_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_req    = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(lca_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(lca_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

`default_nettype wire

### rtl/lca_core.sv
// ----------------------------------------------------------------------------
// lca_core
// Lifting engine: ancestor table and depth memories, add / kth / LCA sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module lca_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire lca_pkg::req_t req,
    output logic               out_valid,
    input  wire logic          out_ready,
    output lca_pkg::node_t     out_node,
    output logic               out_none,
    output lca_pkg::depth_t    out_depth
);

    typedef enum logic [15:0] {
        S_IDLE = 16'h0001,
        S_ROOT = 16'h0002,
        S_ADD0 = 16'h0004,
        S_ADDD = 16'h0008,
        S_ADDL = 16'h0010,
        S_ADDW = 16'h0020,
        S_CLB  = 16'h0040,
        S_CLBW = 16'h0080,
        S_LDEP = 16'h0100,
        S_LEQ  = 16'h0200,
        S_LUP  = 16'h0400,
        S_LUPW = 16'h0800,
        S_LB0  = 16'h1000,
        S_LB0W = 16'h2000,
        S_FIN  = 16'h4000,
        S_OUT  = 16'h8000
    } state_t;

    localparam lca_pkg::lvl_t LVL_LAST = lca_pkg::LVL_W'(lca_pkg::LEVELS - 1);
    localparam lca_pkg::lvl_t LVL_END  = lca_pkg::LVL_W'(lca_pkg::LEVELS);

    // Storage
    lca_pkg::anc_entry_t anc_mem [lca_pkg::ANC_DEPTH];
    lca_pkg::depth_t     dep_mem [lca_pkg::NODES];

    lca_pkg::anc_entry_t anc_rd0_reg, anc_rd1_reg;
    lca_pkg::depth_t     dep_rd0_reg, dep_rd1_reg;

    logic                anc_we;
    lca_pkg::anc_addr_t  anc_wa, anc_ra0, anc_ra1;
    lca_pkg::anc_entry_t anc_wd;
    logic                dep_we;
    lca_pkg::node_t      dep_wa, dep_ra0, dep_ra1;
    lca_pkg::depth_t     dep_wd;

    state_t              state_reg, state_next;
    lca_pkg::node_t      a_reg, a_next;
    lca_pkg::node_t      b_reg, b_next;
    lca_pkg::anc_entry_t cur_reg, cur_next;
    lca_pkg::node_t      v_reg, v_next;
    logic [lca_pkg::K_W-1:0] kq_reg, kq_next;
    lca_pkg::lvl_t       lvl_reg, lvl_next;
    logic                lca_reg, lca_next;
    lca_pkg::node_t      res_reg, res_next;
    logic                none_reg, none_next;
    logic                out_valid_reg, out_valid_next;
    lca_pkg::node_t      out_node_reg, out_node_next;
    logic                out_none_reg, out_none_next;
    lca_pkg::depth_t     out_depth_reg, out_depth_next;

    assign req_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_node  = out_node_reg;
    assign out_none  = out_none_reg;
    assign out_depth = out_depth_reg;

    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        cur_next       = cur_reg;
        v_next         = v_reg;
        kq_next        = kq_reg;
        lvl_next       = lvl_reg;
        lca_next       = lca_reg;
        res_next       = res_reg;
        none_next      = none_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_node_next  = out_node_reg;
        out_none_next  = out_none_reg;
        out_depth_next = out_depth_reg;

        anc_we  = 1'b0;
        anc_wa  = lca_pkg::anc_addr(a_reg, lvl_reg);
        anc_wd  = '0;
        anc_ra0 = lca_pkg::anc_addr(cur_reg.node, lvl_reg);
        anc_ra1 = lca_pkg::anc_addr(v_reg, lvl_reg);
        dep_we  = 1'b0;
        dep_wa  = a_reg;
        dep_wd  = '0;
        dep_ra0 = a_reg;
        dep_ra1 = b_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    a_next    = req.node_a;
                    b_next    = req.node_b;
                    res_next  = req.node_a;
                    none_next = 1'b0;
                    lvl_next  = '0;
                    // Issue both depth reads now for a pair query
                    dep_ra0   = req.node_a;
                    dep_ra1   = req.node_b;
                    case (req.cmd)
                        lca_pkg::CMD_ADD:
                        begin
                            state_next = req.is_root ? S_ROOT : S_ADD0;
                        end
                        lca_pkg::CMD_KTH:
                        begin
                            cur_next   = '{valid: 1'b1, node: req.node_a};
                            kq_next    = req.count_k;
                            lca_next   = 1'b0;
                            state_next = S_CLB;
                        end
                        lca_pkg::CMD_LCA:
                        begin
                            lca_next   = 1'b1;
                            state_next = S_LDEP;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            S_ROOT:
            begin
                anc_we = 1'b1;
                if (lvl_reg == LVL_LAST)
                begin
                    dep_we     = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    lvl_next = lvl_reg + 1'b1;
                end
            end

            S_ADD0:
            begin
                anc_we     = 1'b1;
                anc_wd     = '{valid: 1'b1, node: b_reg};
                cur_next   = '{valid: 1'b1, node: b_reg};
                lvl_next   = lca_pkg::LVL_W'(1);
                state_next = S_ADDD;
            end

            S_ADDD:
            begin
                // Parent depth was read before this node's depth is touched
                dep_we     = 1'b1;
                dep_wd     = (dep_rd1_reg == lca_pkg::DEPTH_MAX) ? lca_pkg::DEPTH_MAX
                                                                 : dep_rd1_reg + 1'b1;
                state_next = S_ADDL;
            end

            S_ADDL:
            begin
                anc_ra0 = lca_pkg::anc_addr(cur_reg.node, lvl_reg - 1'b1);
                if (lvl_reg == LVL_END)
                begin
                    state_next = S_FIN;
                end
                else if (cur_reg.valid)
                begin
                    state_next = S_ADDW;
                end
                else
                begin
                    anc_we   = 1'b1;
                    lvl_next = lvl_reg + 1'b1;
                end
            end

            S_ADDW:
            begin
                anc_we     = 1'b1;
                anc_wd     = anc_rd0_reg;
                cur_next   = anc_rd0_reg;
                lvl_next   = lvl_reg + 1'b1;
                state_next = S_ADDL;
            end

            S_CLB:
            begin
                if (lvl_reg == LVL_END)
                begin
                    if (lca_reg)
                    begin
                        state_next = S_LEQ;
                    end
                    else
                    begin
                        res_next   = cur_reg.node;
                        state_next = S_FIN;
                    end
                end
                else if (kq_reg[lvl_reg[lca_pkg::LVL_W-1:0]])
                begin
                    state_next = S_CLBW;
                end
                else
                begin
                    lvl_next = lvl_reg + 1'b1;
                end
            end

            S_CLBW:
            begin
                if (!anc_rd0_reg.valid)
                begin
                    res_next   = '0;
                    none_next  = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    cur_next.node = anc_rd0_reg.node;
                    lvl_next      = lvl_reg + 1'b1;
                    state_next    = S_CLB;
                end
            end

            S_LDEP:
            begin
                // Lift the deeper node to the depth of the other
                if (dep_rd0_reg < dep_rd1_reg)
                begin
                    cur_next = '{valid: 1'b1, node: b_reg};
                    v_next   = a_reg;
                    kq_next  = lca_pkg::K_W'(dep_rd1_reg - dep_rd0_reg);
                end
                else
                begin
                    cur_next = '{valid: 1'b1, node: a_reg};
                    v_next   = b_reg;
                    kq_next  = lca_pkg::K_W'(dep_rd0_reg - dep_rd1_reg);
                end
                lvl_next   = '0;
                state_next = S_CLB;
            end

            S_LEQ:
            begin
                if (cur_reg.node == v_reg)
                begin
                    res_next   = v_reg;
                    state_next = S_FIN;
                end
                else
                begin
                    lvl_next   = LVL_LAST;
                    state_next = S_LUP;
                end
            end

            S_LUP:
            begin
                state_next = S_LUPW;
            end

            S_LUPW:
            begin
                if (anc_rd0_reg.valid && anc_rd1_reg.valid && (anc_rd0_reg != anc_rd1_reg))
                begin
                    cur_next.node = anc_rd0_reg.node;
                    v_next        = anc_rd1_reg.node;
                end
                if (lvl_reg == '0)
                begin
                    state_next = S_LB0;
                end
                else
                begin
                    lvl_next   = lvl_reg - 1'b1;
                    state_next = S_LUP;
                end
            end

            S_LB0:
            begin
                state_next = S_LB0W;
            end

            S_LB0W:
            begin
                if (!anc_rd0_reg.valid || (anc_rd0_reg != anc_rd1_reg))
                begin
                    res_next  = '0;
                    none_next = 1'b1;
                end
                else
                begin
                    res_next = anc_rd0_reg.node;
                end
                state_next = S_FIN;
            end

            S_FIN:
            begin
                state_next = S_OUT;
            end

            S_OUT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_node_next  = res_reg;
                    out_none_next  = none_reg;
                    out_depth_next = dep_rd0_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        cur_reg       <= cur_next;
        v_reg         <= v_next;
        kq_reg        <= kq_next;
        lvl_reg       <= lvl_next;
        lca_reg       <= lca_next;
        res_reg       <= res_next;
        none_reg      <= none_next;
        out_node_reg  <= out_node_next;
        out_none_reg  <= out_none_next;
        out_depth_reg <= out_depth_next;
    end

    always_ff @(posedge clk)
    begin
        if (anc_we)
        begin
            anc_mem[anc_wa] <= anc_wd;
        end
        anc_rd0_reg <= anc_mem[anc_ra0];
        anc_rd1_reg <= anc_mem[anc_ra1];
    end

    always_ff @(posedge clk)
    begin
        if (dep_we)
        begin
            dep_mem[dep_wa] <= dep_wd;
        end
        dep_rd0_reg <= dep_mem[dep_ra0];
        dep_rd1_reg <= dep_mem[dep_ra1];
    end

endmodule

`default_nettype wire

### rtl/tree_ancestor_lca_engine.sv
// ----------------------------------------------------------------------------
// tree_ancestor_lca_engine
// Binary-lifting ancestor table with add, kth-ancestor and LCA requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel (command in s_tuser), one result per
//   request leaves on the m_ channel, in order. Add requests build a node's
//   ancestor row and depth; a parent must be added before its children.
//   A two-entry queue decouples the input from the sequencer, so requests
//   are taken while the engine works or a result waits on m_tready.
// Sequencing: the sequencer walks the ancestor memory one level per step,
//   one registered read per level. Add root clears the node's row and sets
//   depth zero; add child writes the parent at level 0 and the parent's
//   depth plus one, then fills the higher levels; kth ancestor jumps at the
//   set bits of k; LCA lifts the deeper node by the depth gap, then walks
//   the levels downward. One request is processed at a time.
// Reset clears control state only; table and depth contents are undefined
//   until nodes are added. A stalled m_tready holds the result; the engine
//   then waits with the next result ready to load.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_ancestor_lca_engine (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [9:0] node_a, [19:10] node_b, [20] is_root, [32:21] count_k
    input  wire logic [lca_pkg::IN_DATA_W-1:0] s_tdata,
    // [1:0] command
    input  wire logic [1:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [9:0] result_node, [10] no_ancestor, [20:11] node_depth
    output logic [lca_pkg::OUT_DATA_W-1:0]     m_tdata
);

    lca_pkg::req_t   in_req, q_req;
    logic            q_valid, q_ready;
    lca_pkg::node_t  res_node;
    logic            res_none;
    lca_pkg::depth_t res_depth;

    // Front end: unpack and classify the request
    always_comb
    begin
        in_req.node_a  = s_tdata[9:0];
        in_req.node_b  = s_tdata[19:10];
        in_req.is_root = s_tdata[20];
        in_req.count_k = s_tdata[32:21];
        case (s_tuser)
            lca_pkg::CMD_ADD: in_req.cmd = lca_pkg::CMD_ADD;
            lca_pkg::CMD_KTH: in_req.cmd = lca_pkg::CMD_KTH;
            lca_pkg::CMD_LCA: in_req.cmd = lca_pkg::CMD_LCA;
            default:          in_req.cmd = lca_pkg::CMD_NONE;
        endcase
    end

    lca_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_req   (in_req),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_req    (q_req)
    );

    lca_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (q_valid),
        .req_ready (q_ready),
        .req       (q_req),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_node  (res_node),
        .out_none  (res_none),
        .out_depth (res_depth)
    );

    assign m_tdata = {3'b000, res_depth, res_none, res_node};

endmodule

`default_nettype wire

### rtl/lca_checker.sv
// ----------------------------------------------------------------------------
// lca_checker
// Port-level assertions for the ancestor / LCA engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lca_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // A missing ancestor always reports node zero
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[10] |-> m_tdata[9:0] == 10'd0)
        else $error("no_ancestor with nonzero node");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[23:21] == 3'd0)
        else $error("padding bits set");

endmodule

bind tree_ancestor_lca_engine lca_checker u_lca_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
